/* rtl/miu_pkg.sv */
// Shared types, opcodes and function codes of the integer execute unit.
package miu_pkg;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;

    localparam logic [5:0] FN_SLL   = 6'h00;
    localparam logic [5:0] FN_SRL   = 6'h02;
    localparam logic [5:0] FN_SRA   = 6'h03;
    localparam logic [5:0] FN_SLLV  = 6'h04;
    localparam logic [5:0] FN_SRLV  = 6'h06;
    localparam logic [5:0] FN_SRAV  = 6'h07;
    localparam logic [5:0] FN_MFHI  = 6'h10;
    localparam logic [5:0] FN_MTHI  = 6'h11;
    localparam logic [5:0] FN_MFLO  = 6'h12;
    localparam logic [5:0] FN_MTLO  = 6'h13;
    localparam logic [5:0] FN_MULT  = 6'h18;
    localparam logic [5:0] FN_MULTU = 6'h19;
    localparam logic [5:0] FN_DIV   = 6'h1A;
    localparam logic [5:0] FN_DIVU  = 6'h1B;
    localparam logic [5:0] FN_ADD   = 6'h20;
    localparam logic [5:0] FN_ADDU  = 6'h21;
    localparam logic [5:0] FN_SUB   = 6'h22;
    localparam logic [5:0] FN_SUBU  = 6'h23;
    localparam logic [5:0] FN_AND   = 6'h24;
    localparam logic [5:0] FN_OR    = 6'h25;
    localparam logic [5:0] FN_XOR   = 6'h26;
    localparam logic [5:0] FN_NOR   = 6'h27;
    localparam logic [5:0] FN_SLT   = 6'h2A;
    localparam logic [5:0] FN_SLTU  = 6'h2B;

    localparam logic [31:0] SIGN32 = 32'h8000_0000;
    localparam logic [31:0] ALL32  = 32'hFFFF_FFFF;

    localparam int QDEPTH = 2;

    typedef enum logic [4:0] {
        K_ALU, K_MFHI, K_MFLO, K_MTHI, K_MTLO,
        K_MULT, K_MULTU, K_DIV, K_DIVU, K_UNSUP
    } kind_t;

    typedef enum logic [3:0] {
        A_SLL, A_SRL, A_SRA, A_ADD, A_SUB, A_AND, A_OR, A_XOR, A_NOR,
        A_SLT, A_SLTU, A_LUI
    } aluop_t;

    // One decoded instruction as it travels through the queue.
    typedef struct packed {
        kind_t       kind;
        aluop_t      aluop;
        logic        trap_chk;
        logic        use_imm;
        logic        var_shift;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  dest;
        logic [4:0]  shamt;
        logic [31:0] imm;
    } dec_t;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_MUL1, S_MUL2, S_DIV, S_DONE
    } state_t;

endpackage

/* rtl/miu_decode.sv */
// Front end: accepts instruction words, decodes them and queues them.
module miu_decode (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid_in,
    output logic             ready_in,
    input  logic [31:0]      instr_word,
    output logic             q_valid,
    input  logic             q_pop,
    output miu_pkg::dec_t    q_data
);

    localparam int PW = $clog2(miu_pkg::QDEPTH);

    miu_pkg::dec_t q_mem [miu_pkg::QDEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;
    miu_pkg::dec_t d;

    logic [5:0] op, fn;
    logic [31:0] simm, zimm;

    always_comb
    begin
        op   = instr_word[31:26];
        fn   = instr_word[5:0];
        simm = {{16{instr_word[15]}}, instr_word[15:0]};
        zimm = {16'h0000, instr_word[15:0]};
        d.kind      = miu_pkg::K_ALU;
        d.aluop     = miu_pkg::A_ADD;
        d.trap_chk  = 1'b0;
        d.use_imm   = 1'b0;
        d.var_shift = 1'b0;
        d.rs        = instr_word[25:21];
        d.rt        = instr_word[20:16];
        d.dest      = instr_word[15:11];
        d.shamt     = instr_word[10:6];
        d.imm       = simm;
        if (op == miu_pkg::OP_SPECIAL)
        begin
            case (fn)
                miu_pkg::FN_SLL:   d.aluop = miu_pkg::A_SLL;
                miu_pkg::FN_SRL:   d.aluop = miu_pkg::A_SRL;
                miu_pkg::FN_SRA:   d.aluop = miu_pkg::A_SRA;
                miu_pkg::FN_SLLV:  begin d.aluop = miu_pkg::A_SLL; d.var_shift = 1'b1; end
                miu_pkg::FN_SRLV:  begin d.aluop = miu_pkg::A_SRL; d.var_shift = 1'b1; end
                miu_pkg::FN_SRAV:  begin d.aluop = miu_pkg::A_SRA; d.var_shift = 1'b1; end
                miu_pkg::FN_MFHI:  d.kind = miu_pkg::K_MFHI;
                miu_pkg::FN_MTHI:  d.kind = miu_pkg::K_MTHI;
                miu_pkg::FN_MFLO:  d.kind = miu_pkg::K_MFLO;
                miu_pkg::FN_MTLO:  d.kind = miu_pkg::K_MTLO;
                miu_pkg::FN_MULT:  d.kind = miu_pkg::K_MULT;
                miu_pkg::FN_MULTU: d.kind = miu_pkg::K_MULTU;
                miu_pkg::FN_DIV:   d.kind = miu_pkg::K_DIV;
                miu_pkg::FN_DIVU:  d.kind = miu_pkg::K_DIVU;
                miu_pkg::FN_ADD:   begin d.aluop = miu_pkg::A_ADD; d.trap_chk = 1'b1; end
                miu_pkg::FN_ADDU:  d.aluop = miu_pkg::A_ADD;
                miu_pkg::FN_SUB:   begin d.aluop = miu_pkg::A_SUB; d.trap_chk = 1'b1; end
                miu_pkg::FN_SUBU:  d.aluop = miu_pkg::A_SUB;
                miu_pkg::FN_AND:   d.aluop = miu_pkg::A_AND;
                miu_pkg::FN_OR:    d.aluop = miu_pkg::A_OR;
                miu_pkg::FN_XOR:   d.aluop = miu_pkg::A_XOR;
                miu_pkg::FN_NOR:   d.aluop = miu_pkg::A_NOR;
                miu_pkg::FN_SLT:   d.aluop = miu_pkg::A_SLT;
                miu_pkg::FN_SLTU:  d.aluop = miu_pkg::A_SLTU;
                default:           d.kind = miu_pkg::K_UNSUP;
            endcase
        end
        else
        begin
            d.dest    = instr_word[20:16];
            d.use_imm = 1'b1;
            case (op)
                miu_pkg::OP_ADDI:  begin d.aluop = miu_pkg::A_ADD; d.trap_chk = 1'b1; end
                miu_pkg::OP_ADDIU: d.aluop = miu_pkg::A_ADD;
                miu_pkg::OP_SLTI:  d.aluop = miu_pkg::A_SLT;
                miu_pkg::OP_SLTIU: d.aluop = miu_pkg::A_SLTU;
                miu_pkg::OP_ANDI:  begin d.aluop = miu_pkg::A_AND; d.imm = zimm; end
                miu_pkg::OP_ORI:   begin d.aluop = miu_pkg::A_OR;  d.imm = zimm; end
                miu_pkg::OP_XORI:  begin d.aluop = miu_pkg::A_XOR; d.imm = zimm; end
                miu_pkg::OP_LUI:   begin d.aluop = miu_pkg::A_LUI; d.imm = zimm; end
                default:           d.kind = miu_pkg::K_UNSUP;
            endcase
        end
    end

    logic push;
    assign ready_in = (count_reg != miu_pkg::QDEPTH[PW:0]);
    assign push     = valid_in && ready_in;
    assign q_valid  = (count_reg != '0);
    assign q_data   = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + {{PW{1'b0}}, push} - {{PW{1'b0}}, q_pop};
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= miu_pkg::QDEPTH[PW:0])
        else $error("decode queue overrun");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty decode queue");
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

endmodule

/* rtl/miu_divider.sv */
// Radix-2 restoring divider for unsigned 32-bit magnitudes.
module miu_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic [31:0] q_reg, r_reg, d_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] trial;

    assign busy      = (cnt_reg != 6'd0);
    assign quotient  = q_reg;
    assign remainder = r_reg;
    assign trial     = {r_reg, q_reg[31]} - {1'b0, d_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy)
        begin
            if (!trial[32])
            begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[30:0], q_reg[31]};
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= 6'd32;
        else if (busy)
            cnt_reg <= cnt_reg - 1'b1;
    end

endmodule

/* rtl/miu_execute.sv */
// Back end: register file, ALU, multiply, divide and the result register.
module miu_execute (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_pop,
    input  miu_pkg::dec_t    q_data,
    output logic             valid_out,
    input  logic             ready_out,
    output logic             reg_write,
    output logic [4:0]       dest_reg,
    output logic [31:0]      write_value,
    output logic [31:0]      hi_value,
    output logic [31:0]      lo_value,
    output logic             overflow_trap,
    output logic             unsupported
);

    miu_pkg::state_t state_reg, state_next;
    logic [31:0] gpr [32];
    logic [31:0] hi_reg, lo_reg;
    logic [31:0] a_reg, b_reg;
    miu_pkg::dec_t op_reg;
    logic [31:0] prod_ll_reg, prod_lh_reg, prod_hl_reg, prod_hh_reg;
    logic [31:0] ma_reg, mb_reg;
    logic        qneg_reg, rneg_reg;

    // Result register.
    logic        wr_reg, ovf_reg, uns_reg;
    logic [4:0]  dst_reg;
    logic [31:0] val_reg;

    logic [31:0] opb, sum, diff, alu;
    logic [4:0]  sh;
    logic        ovf;
    logic        div_start, div_busy;
    logic [31:0] div_q, div_r;

    assign opb = op_reg.use_imm ? op_reg.imm : b_reg;
    assign sh  = op_reg.var_shift ? a_reg[4:0] : op_reg.shamt;
    assign sum  = a_reg + opb;
    assign diff = a_reg - opb;

    always_comb
    begin
        ovf = 1'b0;
        case (op_reg.aluop)
            miu_pkg::A_SLL:  alu = b_reg << sh;
            miu_pkg::A_SRL:  alu = b_reg >> sh;
            miu_pkg::A_SRA:  alu = 32'($signed(b_reg) >>> sh);
            miu_pkg::A_ADD:
            begin
                alu = sum;
                ovf = op_reg.trap_chk && !(a_reg[31] ^ opb[31]) && (a_reg[31] ^ sum[31]);
            end
            miu_pkg::A_SUB:
            begin
                alu = diff;
                ovf = op_reg.trap_chk && (a_reg[31] ^ opb[31]) && (a_reg[31] ^ diff[31]);
            end
            miu_pkg::A_AND:  alu = a_reg & opb;
            miu_pkg::A_OR:   alu = a_reg | opb;
            miu_pkg::A_XOR:  alu = a_reg ^ opb;
            miu_pkg::A_NOR:  alu = ~(a_reg | opb);
            miu_pkg::A_SLT:  alu = {31'd0, (a_reg ^ miu_pkg::SIGN32) < (opb ^ miu_pkg::SIGN32)};
            miu_pkg::A_SLTU: alu = {31'd0, a_reg < opb};
            miu_pkg::A_LUI:  alu = {op_reg.imm[15:0], 16'h0000};
            default:         alu = '0;
        endcase
    end

    miu_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (ma_reg),
        .divisor   (mb_reg),
        .busy      (div_busy),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign valid_out = (state_reg == miu_pkg::S_DONE);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            miu_pkg::S_IDLE:
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = miu_pkg::S_READ;
                end
            miu_pkg::S_READ:
                case (op_reg.kind)
                    miu_pkg::K_MULT, miu_pkg::K_MULTU: state_next = miu_pkg::S_MUL1;
                    miu_pkg::K_DIV, miu_pkg::K_DIVU:   state_next = miu_pkg::S_MUL1;
                    default:                           state_next = miu_pkg::S_DONE;
                endcase
            miu_pkg::S_MUL1:
                if (op_reg.kind == miu_pkg::K_DIV || op_reg.kind == miu_pkg::K_DIVU)
                begin
                    div_start  = 1'b1;
                    state_next = miu_pkg::S_DIV;
                end
                else
                    state_next = miu_pkg::S_MUL2;
            miu_pkg::S_MUL2: state_next = miu_pkg::S_DONE;
            miu_pkg::S_DIV:
                if (!div_busy)
                    state_next = miu_pkg::S_DONE;
            miu_pkg::S_DONE:
                if (ready_out)
                    state_next = miu_pkg::S_IDLE;
            default: state_next = miu_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= miu_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Register file: cleared at reset, r0 never written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                gpr[i] <= '0;
            hi_reg <= '0;
            lo_reg <= '0;
        end
        else if (state_reg == miu_pkg::S_READ)
        begin
            if (op_reg.kind == miu_pkg::K_ALU && !ovf && op_reg.dest != 5'd0)
                gpr[op_reg.dest] <= alu;
            if (op_reg.kind == miu_pkg::K_MFHI && op_reg.dest != 5'd0)
                gpr[op_reg.dest] <= hi_reg;
            if (op_reg.kind == miu_pkg::K_MFLO && op_reg.dest != 5'd0)
                gpr[op_reg.dest] <= lo_reg;
            if (op_reg.kind == miu_pkg::K_MTHI)
                hi_reg <= a_reg;
            if (op_reg.kind == miu_pkg::K_MTLO)
                lo_reg <= a_reg;
        end
        else if (state_reg == miu_pkg::S_MUL2)
        begin
            // Partial products summed into the 64-bit result.
            {hi_reg, lo_reg} <= {prod_hh_reg, prod_ll_reg}
                + {16'd0, prod_lh_reg, 16'd0} + {16'd0, prod_hl_reg, 16'd0}
                - (a_reg[31] && op_reg.kind == miu_pkg::K_MULT ? {b_reg, 32'd0} : 64'd0)
                - (b_reg[31] && op_reg.kind == miu_pkg::K_MULT ? {a_reg, 32'd0} : 64'd0);
        end
        else if (state_reg == miu_pkg::S_DIV && !div_busy)
        begin
            if (b_reg == '0)
            begin
                hi_reg <= a_reg;
                lo_reg <= (op_reg.kind == miu_pkg::K_DIV && a_reg[31]) ? 32'd1 : miu_pkg::ALL32;
            end
            else if (op_reg.kind == miu_pkg::K_DIV && a_reg == miu_pkg::SIGN32
                     && b_reg == miu_pkg::ALL32)
            begin
                hi_reg <= '0;
                lo_reg <= miu_pkg::SIGN32;
            end
            else
            begin
                hi_reg <= rneg_reg ? 32'd0 - div_r : div_r;
                lo_reg <= qneg_reg ? 32'd0 - div_q : div_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= q_data;
            a_reg  <= gpr[q_data.rs];
            b_reg  <= gpr[q_data.rt];
        end
        if (state_reg == miu_pkg::S_MUL1)
        begin
            prod_ll_reg <= a_reg[15:0] * b_reg[15:0];
            prod_lh_reg <= a_reg[15:0] * b_reg[31:16];
            prod_hl_reg <= a_reg[31:16] * b_reg[15:0];
            prod_hh_reg <= a_reg[31:16] * b_reg[31:16];
        end
        if (state_reg == miu_pkg::S_READ)
        begin
            if (op_reg.kind == miu_pkg::K_DIV)
            begin
                ma_reg   <= a_reg[31] ? 32'd0 - a_reg : a_reg;
                mb_reg   <= b_reg[31] ? 32'd0 - b_reg : b_reg;
                qneg_reg <= a_reg[31] ^ b_reg[31];
                rneg_reg <= a_reg[31];
            end
            else
            begin
                ma_reg   <= a_reg;
                mb_reg   <= b_reg;
                qneg_reg <= 1'b0;
                rneg_reg <= 1'b0;
            end
            wr_reg  <= 1'b0;
            dst_reg <= '0;
            val_reg <= '0;
            ovf_reg <= 1'b0;
            uns_reg <= (op_reg.kind == miu_pkg::K_UNSUP);
            if (op_reg.dest != 5'd0)
            begin
                if (op_reg.kind == miu_pkg::K_ALU && !ovf)
                begin
                    wr_reg <= 1'b1; dst_reg <= op_reg.dest; val_reg <= alu;
                end
                else if (op_reg.kind == miu_pkg::K_MFHI)
                begin
                    wr_reg <= 1'b1; dst_reg <= op_reg.dest; val_reg <= hi_reg;
                end
                else if (op_reg.kind == miu_pkg::K_MFLO)
                begin
                    wr_reg <= 1'b1; dst_reg <= op_reg.dest; val_reg <= lo_reg;
                end
            end
            if (op_reg.kind == miu_pkg::K_ALU)
                ovf_reg <= ovf;
        end
    end

    assign reg_write     = wr_reg;
    assign dest_reg      = dst_reg;
    assign write_value   = val_reg;
    assign hi_value      = hi_reg;
    assign lo_value      = lo_reg;
    assign overflow_trap = ovf_reg;
    assign unsupported   = uns_reg;

    a_r0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        gpr[0] == 32'd0)
        else $error("r0 was written");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == miu_pkg::S_IDLE)
        else $error("pop while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_out && !ready_out) |=> valid_out && $stable(hi_value) && $stable(lo_value))
        else $error("result changed while stalled");

endmodule

/* rtl/mips_integer_execute_unit.sv */
// Top level of the integer execute unit: decode front end and execute back end.
// One instruction word is taken per input transfer and one result per output
// transfer. A two-entry decode queue sits between the front end and the back
// end. ALU, shift, move and unsupported instructions pass queue pop, execute
// and result in the back end; MULT/MULTU add two registered stages (16x16
// partial products, then their sum), DIV/DIVU a one-bit-per-cycle divider; the
// result register must be emptied before the next instruction starts.
module mips_integer_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    output logic        ready_in,
    input  logic [31:0] instr_word,
    output logic        valid_out,
    input  logic        ready_out,
    output logic        reg_write,
    output logic [4:0]  dest_reg,
    output logic [31:0] write_value,
    output logic [31:0] hi_value,
    output logic [31:0] lo_value,
    output logic        overflow_trap,
    output logic        unsupported
);

    logic          q_valid, q_pop;
    miu_pkg::dec_t q_data;

    miu_decode u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (valid_in),
        .ready_in   (ready_in),
        .instr_word (instr_word),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_data     (q_data)
    );

    miu_execute u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_data        (q_data),
        .valid_out     (valid_out),
        .ready_out     (ready_out),
        .reg_write     (reg_write),
        .dest_reg      (dest_reg),
        .write_value   (write_value),
        .hi_value      (hi_value),
        .lo_value      (lo_value),
        .overflow_trap (overflow_trap),
        .unsupported   (unsupported)
    );

endmodule

/* tb/mips_integer_execute_unit_checker.sv */
// Result checker for the integer execute unit: predicts each instruction and compares.
`timescale 1ns / 1ps
module mips_integer_execute_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    input  logic        ready_in,
    input  logic [31:0] instr_word,
    input  logic        valid_out,
    input  logic        ready_out,
    input  logic        reg_write,
    input  logic [4:0]  dest_reg,
    input  logic [31:0] write_value,
    input  logic [31:0] hi_value,
    input  logic [31:0] lo_value,
    input  logic        overflow_trap,
    input  logic        unsupported,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic        wr;
        logic [4:0]  dest;
        logic [31:0] value;
        logic [31:0] hi;
        logic [31:0] lo;
        logic        ovf;
        logic        unsup;
    } exec_result_t;

    logic [31:0]  gpr [32];
    logic [31:0]  hi_q;
    logic [31:0]  lo_q;
    exec_result_t expected_results[$];

    assign pending_count = expected_results.size();

    function automatic logic [31:0] shift_arith(input logic [31:0] v, input logic [4:0] s);
        return $unsigned($signed(v) >>> s);
    endfunction

    function automatic logic less_signed(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

    // Executes one instruction on the shadow state and returns its result.
    function automatic exec_result_t execute_instr(input logic [31:0] w);
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [31:0] imm;
        logic [31:0] simm;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] val;
        logic [31:0] res;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] r;
        logic [63:0] p;
        logic [4:0]  dest;
        logic        wr;
        logic        ovf;
        logic        unsup;
        exec_result_t o;
        op = w[31:26];
        rs = w[25:21];
        rt = w[20:16];
        rd = w[15:11];
        sh = w[10:6];
        fn = w[5:0];
        imm = {16'h0, w[15:0]};
        simm = {{16{w[15]}}, w[15:0]};
        a = gpr[rs];
        b = gpr[rt];
        val = '0;
        ovf = 1'b0;
        unsup = 1'b0;
        wr = 1'b1;
        if (op == miu_pkg::OP_SPECIAL)
        begin
            dest = rd;
            case (fn)
                miu_pkg::FN_SLL:   val = b << sh;
                miu_pkg::FN_SRL:   val = b >> sh;
                miu_pkg::FN_SRA:   val = shift_arith(b, sh);
                miu_pkg::FN_SLLV:  val = b << a[4:0];
                miu_pkg::FN_SRLV:  val = b >> a[4:0];
                miu_pkg::FN_SRAV:  val = shift_arith(b, a[4:0]);
                miu_pkg::FN_MFHI:  val = hi_q;
                miu_pkg::FN_MFLO:  val = lo_q;
                miu_pkg::FN_MTHI:
                begin
                    hi_q = a;
                    wr = 1'b0;
                end
                miu_pkg::FN_MTLO:
                begin
                    lo_q = a;
                    wr = 1'b0;
                end
                miu_pkg::FN_MULT:
                begin
                    p = $unsigned($signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b}));
                    {hi_q, lo_q} = p;
                    wr = 1'b0;
                end
                miu_pkg::FN_MULTU:
                begin
                    p = {32'h0, a} * {32'h0, b};
                    {hi_q, lo_q} = p;
                    wr = 1'b0;
                end
                miu_pkg::FN_DIV:
                begin
                    wr = 1'b0;
                    if (b == 0)
                    begin
                        lo_q = a[31] ? 32'd1 : miu_pkg::ALL32;
                        hi_q = a;
                    end
                    else if (a == miu_pkg::SIGN32 && b == miu_pkg::ALL32)
                    begin
                        lo_q = miu_pkg::SIGN32;
                        hi_q = '0;
                    end
                    else
                    begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q = ma / mb;
                        r = ma % mb;
                        lo_q = (a[31] ^ b[31]) ? -q : q;
                        hi_q = a[31] ? -r : r;
                    end
                end
                miu_pkg::FN_DIVU:
                begin
                    wr = 1'b0;
                    if (b == 0)
                    begin
                        lo_q = miu_pkg::ALL32;
                        hi_q = a;
                    end
                    else
                    begin
                        lo_q = a / b;
                        hi_q = a % b;
                    end
                end
                miu_pkg::FN_ADD:
                begin
                    res = a + b;
                    ovf = ~(a[31] ^ b[31]) & (a[31] ^ res[31]);
                    val = res;
                end
                miu_pkg::FN_ADDU:  val = a + b;
                miu_pkg::FN_SUB:
                begin
                    res = a - b;
                    ovf = (a[31] ^ b[31]) & (a[31] ^ res[31]);
                    val = res;
                end
                miu_pkg::FN_SUBU:  val = a - b;
                miu_pkg::FN_AND:   val = a & b;
                miu_pkg::FN_OR:    val = a | b;
                miu_pkg::FN_XOR:   val = a ^ b;
                miu_pkg::FN_NOR:   val = ~(a | b);
                miu_pkg::FN_SLT:   val = {31'h0, less_signed(a, b)};
                miu_pkg::FN_SLTU:  val = {31'h0, a < b};
                default:           unsup = 1'b1;
            endcase
        end
        else
        begin
            dest = rt;
            case (op)
                miu_pkg::OP_ADDI:
                begin
                    res = a + simm;
                    ovf = ~(a[31] ^ simm[31]) & (a[31] ^ res[31]);
                    val = res;
                end
                miu_pkg::OP_ADDIU: val = a + simm;
                miu_pkg::OP_SLTI:  val = {31'h0, less_signed(a, simm)};
                miu_pkg::OP_SLTIU: val = {31'h0, a < simm};
                miu_pkg::OP_ANDI:  val = a & imm;
                miu_pkg::OP_ORI:   val = a | imm;
                miu_pkg::OP_XORI:  val = a ^ imm;
                miu_pkg::OP_LUI:   val = {w[15:0], 16'h0};
                default:           unsup = 1'b1;
            endcase
        end
        if (unsup || ovf || dest == 0)
            wr = 1'b0;
        if (wr)
            gpr[dest] = val;
        else
        begin
            dest = '0;
            val = '0;
        end
        o.wr = wr;
        o.dest = dest;
        o.value = val;
        o.hi = hi_q;
        o.lo = lo_q;
        o.ovf = ovf;
        o.unsup = unsup;
        return o;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        hi_q = '0;
        lo_q = '0;
        for (int i = 0; i < 32; i++)
            gpr[i] = '0;
    end

    always @(posedge clk)
    begin
        exec_result_t e;
        if (rst_n)
        begin
            // Result side first; the new instruction cannot affect a result leaving now.
            if (valid_out && ready_out)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result transfers", 32'd1, 32'd0);
                else
                begin
                    e = expected_results.pop_front();
                    if (reg_write !== e.wr)
                        report_mismatch("reg_write", reg_write, e.wr);
                    if (dest_reg !== e.dest)
                        report_mismatch("dest_reg", dest_reg, e.dest);
                    if (write_value !== e.value)
                        report_mismatch("write_value", write_value, e.value);
                    if (hi_value !== e.hi)
                        report_mismatch("hi_value", hi_value, e.hi);
                    if (lo_value !== e.lo)
                        report_mismatch("lo_value", lo_value, e.lo);
                    if (overflow_trap !== e.ovf)
                        report_mismatch("overflow_trap", overflow_trap, e.ovf);
                    if (unsupported !== e.unsup)
                        report_mismatch("unsupported", unsupported, e.unsup);
                end
            end
            if (valid_in && ready_in)
                expected_results.push_back(execute_instr(instr_word));
        end
    end

endmodule

/* tb/mips_integer_execute_unit_tb.sv */
// Top of the integer execute unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module mips_integer_execute_unit_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    // Encodings outside the implemented set, used to check the unsupported flag.
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;

    logic        clk;
    logic        rst_n;
    logic        valid_in;
    logic        ready_in;
    logic [31:0] instr_word;
    logic        valid_out;
    logic        ready_out;
    logic        reg_write;
    logic [4:0]  dest_reg;
    logic [31:0] write_value;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
    logic        overflow_trap;
    logic        unsupported;
    int          fail_count;
    int          pending_count;
    int          idle_cycles;
    bit          hold_results;
    bit          drain_done;

    mips_integer_execute_unit u_dut (.*);
    mips_integer_execute_unit_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // One SPECIAL-format instruction.
    function automatic logic [31:0] r_type(input logic [5:0] fn, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [4:0] rd,
                                           input logic [4:0] sh);
        return {miu_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_type(input logic [5:0] op, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Mostly the implemented operations with random fields, sometimes any word at all.
    function automatic logic [31:0] random_instr();
        logic [5:0] fns[24];
        logic [5:0] ops[8];
        logic [31:0] w;
        logic [15:0] imm;
        fns = '{miu_pkg::FN_SLL, miu_pkg::FN_SRL, miu_pkg::FN_SRA, miu_pkg::FN_SLLV,
                miu_pkg::FN_SRLV, miu_pkg::FN_SRAV, miu_pkg::FN_MFHI, miu_pkg::FN_MTHI,
                miu_pkg::FN_MFLO, miu_pkg::FN_MTLO, miu_pkg::FN_MULT, miu_pkg::FN_MULTU,
                miu_pkg::FN_DIV, miu_pkg::FN_DIVU, miu_pkg::FN_ADD, miu_pkg::FN_ADDU,
                miu_pkg::FN_SUB, miu_pkg::FN_SUBU, miu_pkg::FN_AND, miu_pkg::FN_OR,
                miu_pkg::FN_XOR, miu_pkg::FN_NOR, miu_pkg::FN_SLT, miu_pkg::FN_SLTU};
        ops = '{miu_pkg::OP_ADDI, miu_pkg::OP_ADDIU, miu_pkg::OP_SLTI, miu_pkg::OP_SLTIU,
                miu_pkg::OP_ANDI, miu_pkg::OP_ORI, miu_pkg::OP_XORI, miu_pkg::OP_LUI};
        w = $urandom;
        case ($urandom_range(0, 9))
            0: return w;
            1, 2, 3, 4, 5:
            begin
                // Divides are slow; keep them a small share.
                fns[12] = ($urandom_range(0, 3) == 0) ? miu_pkg::FN_DIV : miu_pkg::FN_MULT;
                fns[13] = ($urandom_range(0, 3) == 0) ? miu_pkg::FN_DIVU : miu_pkg::FN_MULTU;
                return r_type(fns[$urandom_range(0, 23)], w[25:21], w[20:16],
                              w[15:11], w[10:6]);
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0: imm = 16'h8000;
                    1: imm = 16'h7FFF;
                    default: imm = w[15:0];
                endcase
                return i_type(ops[$urandom_range(0, 7)], w[25:21], w[20:16], imm);
            end
        endcase
    endfunction

    task automatic send_instr(input logic [31:0] w);
        repeat ($urandom_range(0, 3)) @(negedge clk);
        valid_in <= 1'b1;
        instr_word <= w;
        @(posedge clk);
        while (!ready_in)
            @(posedge clk);
        @(negedge clk);
        valid_in <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // Receiver: random stall per result, with a long hold-off when asked.
    initial
    begin
        ready_out = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                ready_out <= 1'b0;
                repeat (60) @(negedge clk);
                hold_results = 1'b0;
            end
            ready_out <= 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
            ready_out <= 1'b1;
            @(posedge clk);
            while (!valid_out && !hold_results)
                @(posedge clk);
        end
    end

    initial
    begin
        idle_cycles = 0;
        drain_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if ((valid_in && ready_in) || (valid_out && ready_out))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT && !drain_done)
            begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        logic [31:0] directed[$];
        rst_n = 1'b0;
        valid_in = 1'b0;
        instr_word = '0;
        hold_results = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed = '{
            i_type(miu_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000),     // r1 = most negative
            i_type(miu_pkg::OP_ADDIU, 5'd0, 5'd2, 16'hFFFF),   // r2 = -1
            i_type(miu_pkg::OP_ORI, 5'd1, 5'd3, 16'hFFFF),
            i_type(miu_pkg::OP_LUI, 5'd0, 5'd4, 16'h7FFF),
            i_type(miu_pkg::OP_ORI, 5'd4, 5'd4, 16'hFFFF),     // r4 = most positive
            i_type(miu_pkg::OP_ADDI, 5'd4, 5'd5, 16'h0001),    // overflow trap
            i_type(miu_pkg::OP_ADDI, 5'd1, 5'd5, 16'hFFFF),    // overflow trap
            r_type(miu_pkg::FN_ADD, 5'd4, 5'd4, 5'd6, 5'd0),
            r_type(miu_pkg::FN_SUB, 5'd1, 5'd4, 5'd6, 5'd0),
            r_type(miu_pkg::FN_ADDU, 5'd4, 5'd2, 5'd0, 5'd0),  // write to r0 is discarded
            r_type(miu_pkg::FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0),   // most negative by minus one
            r_type(miu_pkg::FN_DIV, 5'd1, 5'd0, 5'd0, 5'd0),   // divide by zero, negative
            r_type(miu_pkg::FN_DIV, 5'd4, 5'd0, 5'd0, 5'd0),
            r_type(miu_pkg::FN_DIVU, 5'd3, 5'd0, 5'd0, 5'd0),
            r_type(miu_pkg::FN_DIV, 5'd2, 5'd4, 5'd0, 5'd0),
            r_type(miu_pkg::FN_MULT, 5'd1, 5'd1, 5'd0, 5'd0),
            r_type(miu_pkg::FN_MULTU, 5'd2, 5'd2, 5'd0, 5'd0),
            r_type(miu_pkg::FN_MFHI, 5'd0, 5'd0, 5'd7, 5'd0),
            r_type(miu_pkg::FN_MFLO, 5'd0, 5'd0, 5'd8, 5'd0),
            r_type(miu_pkg::FN_SRA, 5'd0, 5'd1, 5'd9, 5'd31),
            r_type(miu_pkg::FN_SRAV, 5'd2, 5'd1, 5'd9, 5'd0),
            i_type(miu_pkg::OP_SLTI, 5'd1, 5'd10, 16'h8000),
            i_type(miu_pkg::OP_SLTIU, 5'd2, 5'd10, 16'hFFFF),
            i_type(OP_JAL, 5'd0, 5'd0, 16'h0000),              // jump and link: unsupported
            r_type(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0)         // system call: unsupported
        };
        foreach (directed[i])
            send_instr(directed[i]);

        for (int n = 0; n < 600; n++)
        begin
            if (n == 150)
                hold_results = 1'b1;
            if (n == 350)
            begin
                wait_drained();
                repeat (40) @(negedge clk);
            end
            send_instr(random_instr());
        end

        wait_drained();
        drain_done = 1'b1;
        repeat (50) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/miu_pkg.sv
rtl/miu_decode.sv
rtl/miu_divider.sv
rtl/miu_execute.sv
rtl/mips_integer_execute_unit.sv
tb/mips_integer_execute_unit_checker.sv
tb/mips_integer_execute_unit_tb.sv
